@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the transfer credit table.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent, outside of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/kctc_pkg.sv @@
// Shared types and constants of the keyed transfer credit table.
// No dependencies; imported by kctc_cell, the top level and the testbench.
`timescale 1ns / 1ps

package kctc_pkg;

    localparam int KEY_W             = 64;
    localparam int CNT_W             = 64;
    localparam int SCORE_W           = 56;
    localparam int CREDIT_BASE       = 1000;
    localparam int SCORE_SHIFT       = 10;
    localparam int TABLE_ENTRIES_DEF = 256;

    // Command codes. The unused code behaves as a query.
    localparam logic [1:0] CMD_QUERY    = 2'd0;
    localparam logic [1:0] CMD_ADD_UP   = 2'd1;
    localparam logic [1:0] CMD_ADD_DOWN = 2'd2;

    // One request as it travels down the cell chain, together with its result so far.
    typedef struct packed {
        logic [1:0]       cmd;
        logic [KEY_W-1:0] key_high;
        logic [KEY_W-1:0] key_low;
        logic [CNT_W-1:0] amount;
        logic             hit;
        logic [CNT_W-1:0] up_total;
        logic [CNT_W-1:0] down_total;
    } t_item;

    function automatic logic is_add_cmd(input logic [1:0] cmd);
        return (cmd == CMD_ADD_UP) || (cmd == CMD_ADD_DOWN);
    endfunction

endpackage

@@ hw/rtl/kctc_cell.sv @@
// One entry cell of the credit table chain: holds a key and its two counters.
// Depends on kctc_pkg; instantiated in a row by keyed_transfer_credit_table_unit.
`timescale 1ns / 1ps

module kctc_cell #(
    parameter int CELL_IDX = 0,
    parameter int USED_W   = 9
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  kctc_pkg::t_item     i_item,
    input  logic [USED_W-1:0]   i_used,
    output logic                o_valid,
    output kctc_pkg::t_item     o_item,
    output logic                o_create
);
    import kctc_pkg::*;

    localparam logic [USED_W-1:0] IDX = USED_W'(CELL_IDX);

    logic             r_valid;
    t_item            r_item;
    logic [KEY_W-1:0] r_key_high;
    logic [KEY_W-1:0] r_key_low;
    logic [CNT_W-1:0] r_up;
    logic [CNT_W-1:0] r_down;

    logic             w_live;
    logic             w_match;
    logic             w_create;
    logic             w_take;
    logic [CNT_W-1:0] w_base_up;
    logic [CNT_W-1:0] w_base_down;
    logic [CNT_W-1:0] n_up;
    logic [CNT_W-1:0] n_down;
    t_item            n_item;

    // A cell is in use when its index lies below the fill count; slots fill in order.
    assign w_live   = i_valid && !i_item.hit;
    assign w_match  = w_live && (i_used > IDX)
                   && (r_key_high == i_item.key_high) && (r_key_low == i_item.key_low);
    assign w_create = w_live && is_add_cmd(i_item.cmd) && (i_used == IDX);
    assign w_take   = w_match || w_create;

    assign w_base_up   = w_create ? '0 : r_up;
    assign w_base_down = w_create ? '0 : r_down;
    assign n_up   = w_base_up   + ((i_item.cmd == CMD_ADD_UP)   ? i_item.amount : '0);
    assign n_down = w_base_down + ((i_item.cmd == CMD_ADD_DOWN) ? i_item.amount : '0);

    always_comb begin
        n_item = i_item;
        if (w_take) begin
            n_item.hit        = 1'b1;
            n_item.up_total   = n_up;
            n_item.down_total = n_down;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
            if (w_take && is_add_cmd(i_item.cmd)) begin
                r_up   <= n_up;
                r_down <= n_down;
            end
            if (w_create) begin
                r_key_high <= i_item.key_high;
                r_key_low  <= i_item.key_low;
            end
        end
    end

    assign o_valid  = r_valid;
    assign o_item   = r_item;
    assign o_create = i_en && w_create;

endmodule

@@ hw/rtl/keyed_transfer_credit_table_unit.sv @@
// Top level of the keyed transfer credit table: input handshake, cell chain, result register.
// Depends on kctc_pkg, kctc_cell and assert_macros.svh.
`timescale 1ns / 1ps

// The table holds up to TABLE_ENTRIES peers, each keyed by a 128-bit hash and
// carrying an uploaded and a downloaded byte counter that wrap at 2^64. Every
// request is a query or an add to one counter; an add of an unknown key claims
// the next free entry, and an add of an unknown key into a full table is
// refused with table_full set. Each request returns one transfer with found,
// both totals and the credit score 1000 + uploaded/1024 - downloaded/1024.
// Requests travel down a row of TABLE_ENTRIES cells, one cell per cycle while the
// row moves, and each cell compares and updates the one entry it owns as a request
// passes. Because requests stay in order along the row, a later request always
// sees the effect of every earlier one, so while the row moves a new request is
// taken every cycle and throughput is one transfer per cycle. The first cell
// captures the request at the transfer edge itself; the request then passes each
// later cell's register in order and finally the output register that computes
// the score. When the result register is full and not being taken, the whole row
// holds and the input is not ready.
// No clearing pass is needed after reset; the entry count restarts at zero.

module keyed_transfer_credit_table_unit #(
    parameter int TABLE_ENTRIES = kctc_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [1:0]                            i_cmd,
    input  logic [kctc_pkg::KEY_W-1:0]            i_key_high,
    input  logic [kctc_pkg::KEY_W-1:0]            i_key_low,
    input  logic [kctc_pkg::CNT_W-1:0]            i_amount,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic                                  o_found,
    output logic                                  o_table_full,
    output logic [kctc_pkg::CNT_W-1:0]            o_uploaded_total,
    output logic [kctc_pkg::CNT_W-1:0]            o_downloaded_total,
    output logic signed [kctc_pkg::SCORE_W-1:0]   o_credit_score
);
    import kctc_pkg::*;

`include "assert_macros.svh"

    localparam int USED_W = $clog2(TABLE_ENTRIES + 1);

    logic                     w_advance;
    logic                     w_valid [TABLE_ENTRIES+1];
    t_item                    w_item  [TABLE_ENTRIES+1];
    logic [TABLE_ENTRIES-1:0] w_create;
    logic [USED_W-1:0]        r_used;
    t_item                    w_last;

    logic                     r_out_valid;
    logic                     r_found;
    logic                     r_table_full;
    logic [CNT_W-1:0]         r_up;
    logic [CNT_W-1:0]         r_down;
    logic [SCORE_W-1:0]       r_score;
    logic [SCORE_W-1:0]       n_score;

    // The row moves whenever the result register is empty or is being taken.
    assign w_advance  = !r_out_valid || i_out_ready;
    assign o_in_ready = w_advance;

    // A request enters the first cell with no hit and zero totals.
    assign w_valid[0]            = i_in_valid;
    assign w_item[0].cmd         = i_cmd;
    assign w_item[0].key_high    = i_key_high;
    assign w_item[0].key_low     = i_key_low;
    assign w_item[0].amount      = i_amount;
    assign w_item[0].hit         = 1'b0;
    assign w_item[0].up_total    = '0;
    assign w_item[0].down_total  = '0;

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        kctc_cell #(
            .CELL_IDX (g),
            .USED_W   (USED_W)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_advance),
            .i_valid  (w_valid[g]),
            .i_item   (w_item[g]),
            .i_used   (r_used),
            .o_valid  (w_valid[g+1]),
            .o_item   (w_item[g+1]),
            .o_create (w_create[g])
        );
    end

    // Only the cell whose index equals the fill count can claim an entry,
    // so at most one create happens in any cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (|w_create) begin
            r_used <= r_used + USED_W'(1);
        end
    end

    // A request that leaves the row unresolved was an add into a full table
    // if it was an add at all: any add reaches the first free cell otherwise.
    assign w_last  = w_item[TABLE_ENTRIES];
    assign n_score = SCORE_W'(CREDIT_BASE)
                   + SCORE_W'(w_last.up_total >> SCORE_SHIFT)
                   - SCORE_W'(w_last.down_total >> SCORE_SHIFT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_valid[TABLE_ENTRIES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_valid[TABLE_ENTRIES]) begin
            r_found      <= w_last.hit;
            r_table_full <= is_add_cmd(w_last.cmd) && !w_last.hit;
            r_up         <= w_last.up_total;
            r_down       <= w_last.down_total;
            r_score      <= n_score;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_found            = r_found;
    assign o_table_full       = r_table_full;
    assign o_uploaded_total   = r_up;
    assign o_downloaded_total = r_down;
    assign o_credit_score     = signed'(r_score);

    `ASSERT_ALWAYS(a_one_create, i_clk, i_rst_n, $onehot0(w_create),
                   "two cells created an entry")
    `ASSERT_ALWAYS(a_used_bound, i_clk, i_rst_n, r_used <= USED_W'(TABLE_ENTRIES),
                   "fill count overflow")
    `ASSERT_NEXT(a_used_step, i_clk, i_rst_n, |w_create,
                 r_used == $past(r_used) + USED_W'(1), "fill count did not step on create")
    `ASSERT_ALWAYS(a_full_excl, i_clk, i_rst_n, !(r_out_valid && r_found && r_table_full),
                   "result both found and refused")

endmodule

@@ tb/tb_top.sv @@
// Testbench for keyed_transfer_credit_table_unit: directed and random traffic with self-checking.
// Depends on kctc_pkg and the RTL of the table; a built-in credit predictor supplies expected results.
`timescale 1ns / 1ps

module tb_top;
    import kctc_pkg::*;

    localparam int TABLE_ENTRIES = TABLE_ENTRIES_DEF;
    // The fourth command code has no meaning of its own and must behave as a query.
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [CNT_W-1:0] ALL_ONES = {CNT_W{1'b1}};

    // Clock and a synchronous reset that is released once.
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #2 i_clk = ~i_clk;

    // Every input starts at a known value.
    logic             i_in_valid = 1'b0;
    logic             o_in_ready;
    logic [1:0]       i_cmd = CMD_QUERY;
    logic [KEY_W-1:0] i_key_high = '0;
    logic [KEY_W-1:0] i_key_low = '0;
    logic [CNT_W-1:0] i_amount = '0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    logic             o_found;
    logic             o_table_full;
    logic [CNT_W-1:0] o_uploaded_total;
    logic [CNT_W-1:0] o_downloaded_total;
    logic signed [SCORE_W-1:0] o_credit_score;

    keyed_transfer_credit_table_unit #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_cmd             (i_cmd),
        .i_key_high        (i_key_high),
        .i_key_low         (i_key_low),
        .i_amount          (i_amount),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_found           (o_found),
        .o_table_full      (o_table_full),
        .o_uploaded_total  (o_uploaded_total),
        .o_downloaded_total(o_downloaded_total),
        .o_credit_score    (o_credit_score)
    );

    // One expected result transfer, field for field as the block presents it.
    typedef struct packed {
        logic               found;
        logic               table_full;
        logic [CNT_W-1:0]   uploaded_total;
        logic [CNT_W-1:0]   downloaded_total;
        logic [SCORE_W-1:0] credit_score;
    } t_credit_result;

    // The testbench's own copy of the peer table. Slots fill in order, and only
    // slots below peers_used are ever looked at.
    logic [KEY_W-1:0] peer_key_high [TABLE_ENTRIES];
    logic [KEY_W-1:0] peer_key_low  [TABLE_ENTRIES];
    logic [CNT_W-1:0] peer_uploaded [TABLE_ENTRIES];
    logic [CNT_W-1:0] peer_downloaded [TABLE_ENTRIES];
    int               peers_used = 0;

    t_credit_result pending_credits[$];
    int             error_count = 0;

    // Knobs shared by the test tasks, the sending task and the receiver process.
    bit send_gaps_on = 1'b0;
    bit sink_stalls_on = 1'b0;
    int sink_hold_cycles = 0;

    // Applies one accepted request to the table copy and queues the result it
    // must produce. An add of an unknown key claims the next slot unless the
    // table is full, in which case nothing changes and the refusal is flagged.
    function automatic void predict_credit(input logic [1:0] cmd,
                                           input logic [KEY_W-1:0] key_high,
                                           input logic [KEY_W-1:0] key_low,
                                           input logic [CNT_W-1:0] amount);
        int             slot;
        t_credit_result res;
        logic [63:0]    score;
        slot = -1;
        res = '0;
        for (int i = 0; i < peers_used; i++) begin
            if (slot < 0 && peer_key_high[i] == key_high && peer_key_low[i] == key_low) begin
                slot = i;
            end
        end
        if (cmd == CMD_ADD_UP || cmd == CMD_ADD_DOWN) begin
            if (slot < 0) begin
                if (peers_used < TABLE_ENTRIES) begin
                    slot = peers_used;
                    peer_key_high[slot] = key_high;
                    peer_key_low[slot] = key_low;
                    peer_uploaded[slot] = '0;
                    peer_downloaded[slot] = '0;
                    peers_used++;
                end else begin
                    res.table_full = 1'b1;
                end
            end
            if (slot >= 0) begin
                if (cmd == CMD_ADD_UP) begin
                    peer_uploaded[slot] = peer_uploaded[slot] + amount;
                end else begin
                    peer_downloaded[slot] = peer_downloaded[slot] + amount;
                end
            end
        end
        if (slot >= 0) begin
            res.found = 1'b1;
            res.uploaded_total = peer_uploaded[slot];
            res.downloaded_total = peer_downloaded[slot];
            // Both quotients stay below 2^54, so wrapping 64-bit arithmetic
            // followed by truncation gives the signed 56-bit score.
            score = 64'(CREDIT_BASE) + (peer_uploaded[slot] >> SCORE_SHIFT)
                    - (peer_downloaded[slot] >> SCORE_SHIFT);
            res.credit_score = score[SCORE_W-1:0];
        end else begin
            res.credit_score = SCORE_W'(CREDIT_BASE);
        end
        pending_credits = {pending_credits, res};
    endfunction

    // Offers one request and returns at the edge where it is transferred. The
    // next call drives the channel in that same time step, so valid either
    // stays high for a back-to-back request or drops for a gap, never both.
    task automatic send_request(input logic [1:0] cmd,
                                input logic [KEY_W-1:0] key_high,
                                input logic [KEY_W-1:0] key_low,
                                input logic [CNT_W-1:0] amount);
        if (send_gaps_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd <= cmd;
        i_key_high <= key_high;
        i_key_low <= key_low;
        i_amount <= amount;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_credit(cmd, key_high, key_low, amount);
    endtask

    function automatic logic [63:0] random_word();
        return {$urandom, $urandom};
    endfunction

    // Amounts lean toward the interesting spots: zero, the 1024-byte step of
    // the score, values that wrap a counter, and fully random words.
    function automatic logic [CNT_W-1:0] random_amount();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return CNT_W'($urandom_range(0, 4096));
            2: return ALL_ONES - CNT_W'($urandom_range(0, 4096));
            3: return CNT_W'($urandom_range(0, 1023)) << ($urandom_range(0, 54));
            default: return random_word();
        endcase
    endfunction

    // Mostly keys already in the table so that counters grow and wrap, plus
    // brand new keys, keys one bit away from a known one, keys that share a
    // half with a known one, and keys whose halves are each all zeros or all ones.
    function automatic void random_request(output logic [1:0] cmd,
                                           output logic [KEY_W-1:0] key_high,
                                           output logic [KEY_W-1:0] key_low,
                                           output logic [CNT_W-1:0] amount);
        int pick;
        int slot;
        int bit_pos;
        pick = $urandom_range(0, 99);
        if (pick < 25) cmd = CMD_QUERY;
        else if (pick < 60) cmd = CMD_ADD_UP;
        else if (pick < 95) cmd = CMD_ADD_DOWN;
        else cmd = CMD_UNUSED;
        amount = random_amount();
        key_high = random_word();
        key_low = random_word();
        pick = $urandom_range(0, 99);
        if (peers_used > 0 && pick < 75) begin
            slot = $urandom_range(0, peers_used - 1);
            key_high = peer_key_high[slot];
            key_low = peer_key_low[slot];
            bit_pos = $urandom_range(0, KEY_W - 1);
            if (pick >= 70) begin
                key_low = random_word();
            end else if (pick >= 62) begin
                if ($urandom_range(0, 1) == 0) key_high[bit_pos] = ~key_high[bit_pos];
                else key_low[bit_pos] = ~key_low[bit_pos];
            end
        end else if (pick >= 95) begin
            key_high = ($urandom_range(0, 1) == 0) ? '0 : ALL_ONES;
            key_low = ($urandom_range(0, 1) == 0) ? '0 : ALL_ONES;
        end
    endfunction

    task automatic send_random_requests(input int count);
        logic [1:0]       cmd;
        logic [KEY_W-1:0] key_high;
        logic [KEY_W-1:0] key_low;
        logic [CNT_W-1:0] amount;
        repeat (count) begin
            random_request(cmd, key_high, key_low, amount);
            send_request(cmd, key_high, key_low, amount);
        end
    endtask

    // Receiver side. Each pass drives ready once, in one time step: either a
    // long hold that a test asked for, a short random stall, or one cycle ready.
    initial begin
        int stall;
        forever begin
            @(posedge i_clk);
            if (sink_hold_cycles > 0) begin
                stall = sink_hold_cycles;
                sink_hold_cycles = 0;
                i_out_ready <= 1'b0;
                repeat (stall - 1) @(posedge i_clk);
            end else if (sink_stalls_on && $urandom_range(0, 4) == 0) begin
                stall = $urandom_range(1, 13);
                i_out_ready <= 1'b0;
                repeat (stall - 1) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Result checker. Outputs are sampled at the edge where the transfer takes
    // place, before the block's own updates for that edge land.
    always @(posedge i_clk) begin
        t_credit_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_credits.size() == 0) begin
                $error("result transfer arrived with no request outstanding");
                error_count++;
            end else begin
                want = pending_credits.pop_front();
                if (o_found !== want.found) begin
                    $error("found: expected %0d, actual %0d", want.found, o_found);
                    error_count++;
                end
                if (o_table_full !== want.table_full) begin
                    $error("table_full: expected %0d, actual %0d", want.table_full,
                           o_table_full);
                    error_count++;
                end
                if (o_uploaded_total !== want.uploaded_total) begin
                    $error("uploaded_total: expected %h, actual %h", want.uploaded_total,
                           o_uploaded_total);
                    error_count++;
                end
                if (o_downloaded_total !== want.downloaded_total) begin
                    $error("downloaded_total: expected %h, actual %h",
                           want.downloaded_total, o_downloaded_total);
                    error_count++;
                end
                if (o_credit_score !== want.credit_score) begin
                    $error("credit_score: expected %0d, actual %0d",
                           $signed(want.credit_score), o_credit_score);
                    error_count++;
                end
            end
        end
    end

    // Absent keys, zero-byte adds, counters at their limits and wrapping, the
    // score on both sides of the 1024-byte step, the unused command code, and
    // keys that differ from a stored key in only one half.
    task automatic test_directed_cases();
        logic [KEY_W-1:0] alt_a;
        logic [KEY_W-1:0] alt_b;
        alt_a = {(KEY_W/2){2'b10}};
        alt_b = {(KEY_W/2){2'b01}};
        send_request(CMD_QUERY, '0, '0, ALL_ONES);
        send_request(CMD_UNUSED, ALL_ONES, ALL_ONES, ALL_ONES);
        send_request(CMD_ADD_UP, '0, '0, '0);
        send_request(CMD_QUERY, '0, '0, ALL_ONES);
        send_request(CMD_ADD_UP, '0, '0, ALL_ONES);
        send_request(CMD_ADD_UP, '0, '0, 64'd1);
        send_request(CMD_ADD_DOWN, ALL_ONES, ALL_ONES, ALL_ONES);
        send_request(CMD_ADD_DOWN, ALL_ONES, ALL_ONES, 64'd2);
        send_request(CMD_ADD_UP, ALL_ONES, ALL_ONES, 64'd1023);
        send_request(CMD_ADD_UP, ALL_ONES, ALL_ONES, 64'd1);
        send_request(CMD_UNUSED, ALL_ONES, ALL_ONES, ALL_ONES);
        send_request(CMD_ADD_UP, ALL_ONES, '0, 64'd1024);
        send_request(CMD_ADD_DOWN, '0, ALL_ONES, 64'd1025024);
        send_request(CMD_QUERY, ALL_ONES, 64'd1, '0);
        send_request(CMD_ADD_UP, alt_a, alt_b, alt_b);
        send_request(CMD_ADD_DOWN, alt_b, alt_a, alt_a);
        send_request(CMD_QUERY, alt_a, alt_a, alt_a);
        send_request(CMD_ADD_DOWN, alt_a, alt_b, ALL_ONES);
        send_request(CMD_QUERY, alt_a, alt_b, '0);
    endtask

    task automatic test_random_traffic();
        send_gaps_on = 1'b1;
        sink_stalls_on = 1'b1;
        send_random_requests(650);
    endtask

    // The receiver holds off far longer than the pipeline is deep while the
    // sender keeps offering back to back, so the row fills and input stalls.
    task automatic test_output_backpressure();
        send_gaps_on = 1'b0;
        sink_stalls_on = 1'b0;
        sink_hold_cycles = 3 * TABLE_ENTRIES;
        send_random_requests(350);
        send_gaps_on = 1'b1;
        sink_stalls_on = 1'b1;
    endtask

    // Claims the remaining slots with new keys, then keeps adding new keys
    // into the full table while known keys are still updated and queried.
    task automatic test_table_fill();
        logic [1:0]       cmd;
        logic [KEY_W-1:0] key_high;
        logic [KEY_W-1:0] key_low;
        logic [CNT_W-1:0] amount;
        while (peers_used < TABLE_ENTRIES) begin
            cmd = ($urandom_range(0, 1) == 0) ? CMD_ADD_UP : CMD_ADD_DOWN;
            send_request(cmd, random_word(), random_word(), random_amount());
        end
        repeat (150) begin
            random_request(cmd, key_high, key_low, amount);
            if ($urandom_range(0, 2) == 0) begin
                cmd = ($urandom_range(0, 1) == 0) ? CMD_ADD_UP : CMD_ADD_DOWN;
                key_high = random_word();
                key_low = random_word();
            end
            send_request(cmd, key_high, key_low, amount);
        end
    endtask

    // Closing stretch at full rate with no idling on either side.
    task automatic test_full_table_traffic();
        send_gaps_on = 1'b0;
        sink_stalls_on = 1'b0;
        send_random_requests(450);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_gaps_on = 1'b1;
        sink_stalls_on = 1'b1;
        test_directed_cases();
        test_random_traffic();
        test_output_backpressure();
        test_table_fill();
        test_full_table_traffic();
        i_in_valid <= 1'b0;
        // Drain, then allow one more pass through the row to catch strays.
        while (pending_credits.size() != 0) @(posedge i_clk);
        repeat (TABLE_ENTRIES + 16) @(posedge i_clk);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/kctc_pkg.sv
hw/rtl/kctc_cell.sv
hw/rtl/keyed_transfer_credit_table_unit.sv
tb/tb_top.sv
